// File: src/sv39ptw_pkg.sv
`default_nettype none

package sv39ptw_pkg;

  localparam int VA_W = 38;
  localparam int PPN_W = 44;
  localparam int PERM_W = 4;
  localparam int COUNT_W = 13;
  localparam int PA_W = 56;
  localparam int STATUS_W = 3;
  localparam int CMD_W = 2;
  localparam int PTE_W = 54;

  localparam int S_TDATA_W = 104;
  localparam int M_TDATA_W = 72;

  localparam logic [CMD_W-1:0] CMD_MAP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_UNMAP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ_CHECK = 2'd2;
  localparam logic [CMD_W-1:0] CMD_WRITE_CHECK = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MISALIGNED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REMAP = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOPAGE = 3'd4;
  localparam logic [STATUS_W-1:0] ST_UNMAPPED = 3'd5;
  localparam logic [STATUS_W-1:0] ST_NOTLEAF = 3'd6;
  localparam logic [STATUS_W-1:0] ST_DENIED = 3'd7;

  localparam logic [9:0] FLAGS_POINTER = 10'h001;

  typedef struct packed {
    logic [PPN_W-1:0] ppn;
    logic [9:0] flags;
  } pte_t;

endpackage

`default_nettype wire

// File: src/sv39_page_table_walker.sv
// Walk: each level takes a table read state and an evaluate state, so a full three-level walk
// makes three dependent table reads before its result; a walk that stops at the top or middle
// level ends early, misaligned items and zero-length checks go straight to the result state,
// and a result waits while the output register is stalled.
// Flow: one item at a time; the next item is accepted once the result has moved into the
// output register. Reset: synchronous; a clearing pass then zeroes all TABLE_PAGES*512 entries
// of the table memory while no item is accepted. Configuration writes are taken at any time.
`default_nettype none

module sv39_page_table_walker #(
  parameter int TABLE_PAGES = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [sv39ptw_pkg::PPN_W-1:0]       cfg_data,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // virtual_address, phys_page, permission_bits, release_after_unmap, byte_count, zero pad
  input  wire logic [sv39ptw_pkg::S_TDATA_W-1:0]   s_tdata,
  // command
  input  wire logic [sv39ptw_pkg::CMD_W-1:0]       s_tuser,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // status, phys_address, chunk_bytes
  output logic [sv39ptw_pkg::M_TDATA_W-1:0]        m_tdata,
  // page_released
  output logic                                     m_tuser
);
  import sv39ptw_pkg::*;

  localparam int PW = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
  localparam int NW = $clog2(TABLE_PAGES + 1);
  localparam int AW = PW + 9;
  localparam int DEPTH = TABLE_PAGES * 512;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EVAL,
    S_DONE
  } state_t;

  state_t state;
  logic [AW-1:0] clr_addr;
  logic [NW-1:0] next_free;
  logic [PPN_W-1:0] base_ppn;
  logic [1:0] lvl;
  logic [PW-1:0] cur_page;

  logic [CMD_W-1:0] cmd;
  logic [VA_W-1:0] va;
  logic [PPN_W-1:0] ppn;
  logic [PERM_W-1:0] perm;
  logic release_req;
  logic [COUNT_W-1:0] count;

  logic [STATUS_W-1:0] res_status;
  logic [PA_W-1:0] res_pa;
  logic res_rel;
  logic [COUNT_W-1:0] res_chunk;

  logic [STATUS_W-1:0] out_status;
  logic [PA_W-1:0] out_pa;
  logic out_rel;
  logic [COUNT_W-1:0] out_chunk;

  logic [PTE_W:0] mem [DEPTH];
  logic [PTE_W:0] rd_q;

  logic mem_we;
  logic [AW-1:0] mem_waddr;
  logic [PTE_W:0] mem_wdata;
  logic [8:0] vpn;
  logic [AW-1:0] slot_addr;
  logic page_alloc;
  pte_t ent;
  logic [PPN_W-1:0] ptr_off;

  logic ev_done;
  logic [STATUS_W-1:0] ev_status;
  logic [PA_W-1:0] ev_pa;
  logic ev_rel;
  logic [COUNT_W-1:0] ev_chunk;
  logic ev_alloc;
  logic [PW-1:0] ev_page;
  logic ev_wr;
  pte_t ev_wdata;
  logic [COUNT_W-1:0] room;

  logic [VA_W-1:0] in_va;
  logic [CMD_W-1:0] in_cmd;
  logic [COUNT_W-1:0] in_count;
  logic in_fire;

  assign in_va = s_tdata[37:0];
  assign in_cmd = s_tuser;
  assign in_count = s_tdata[99:87];
  assign in_fire = s_tvalid && s_tready;

  assign cfg_ready = 1'b1;
  assign s_tready = (state == S_IDLE);
  assign m_tdata = {out_chunk, out_pa, out_status};
  assign m_tuser = out_rel;

  always_comb begin
    case (lvl)
      2'd2: vpn = {1'b0, va[37:30]};
      2'd1: vpn = va[29:21];
      default: vpn = va[20:12];
    endcase
  end

  assign slot_addr = {cur_page, vpn};
  assign page_alloc = NW'(cur_page) < next_free;
  assign ent = (rd_q[PTE_W] || !page_alloc) ? pte_t'(rd_q[PTE_W-1:0]) : '0;
  assign ptr_off = ent.ppn - base_ppn;
  assign room = 13'd4096 - {1'b0, va[11:0]};

  always_comb begin
    ev_done = 1'b0;
    ev_status = ST_OK;
    ev_pa = '0;
    ev_rel = 1'b0;
    ev_chunk = '0;
    ev_alloc = 1'b0;
    ev_page = cur_page;
    ev_wr = 1'b0;
    ev_wdata = '0;
    if (lvl != 2'd0) begin
      if (ent.flags[0]) begin
        if (ptr_off >= PPN_W'(TABLE_PAGES)) begin
          ev_done = 1'b1;
          ev_status = ST_RANGE;
        end else begin
          ev_page = ptr_off[PW-1:0];
        end
      end else if (cmd != CMD_MAP) begin
        ev_done = 1'b1;
        ev_status = ST_UNMAPPED;
      end else if (next_free >= NW'(TABLE_PAGES)) begin
        ev_done = 1'b1;
        ev_status = ST_NOPAGE;
      end else begin
        ev_alloc = 1'b1;
        ev_page = next_free[PW-1:0];
        ev_wr = 1'b1;
        ev_wdata.ppn = base_ppn + PPN_W'(next_free);
        ev_wdata.flags = FLAGS_POINTER;
      end
    end else begin
      ev_done = 1'b1;
      case (cmd)
        CMD_MAP: begin
          if (ent.flags[0]) begin
            ev_status = ST_REMAP;
          end else begin
            ev_wr = 1'b1;
            ev_wdata.ppn = ppn;
            ev_wdata.flags = {5'd0, perm, 1'b1};
            ev_pa = {ppn, 12'd0};
          end
        end
        CMD_UNMAP: begin
          if (!ent.flags[0]) begin
            ev_status = ST_UNMAPPED;
          end else if (ent.flags == FLAGS_POINTER) begin
            ev_status = ST_NOTLEAF;
          end else begin
            ev_wr = 1'b1;
            if (release_req) begin
              ev_pa = {ent.ppn, 12'd0};
              ev_rel = 1'b1;
            end
          end
        end
        default: begin
          if (!ent.flags[0]) begin
            ev_status = ST_UNMAPPED;
          end else if (!ent.flags[4] || (cmd == CMD_WRITE_CHECK && !ent.flags[2])) begin
            ev_status = ST_DENIED;
          end else begin
            ev_pa = {ent.ppn, va[11:0]};
            ev_chunk = (count < room) ? count : room;
          end
        end
      endcase
    end
  end

  // A page that is allocated by this very write counts as allocated for its own link entry.
  always_comb begin
    mem_we = 1'b0;
    mem_waddr = slot_addr;
    mem_wdata = '0;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
      mem_waddr = clr_addr;
    end else if (state == S_EVAL && ev_wr) begin
      mem_we = 1'b1;
      mem_wdata = {page_alloc || (ev_alloc && NW'(cur_page) == next_free), ev_wdata};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (state == S_READ) begin
      rd_q <= mem[slot_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      next_free <= NW'(1);
      base_ppn <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        base_ppn <= cfg_data;
      end
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            cmd <= in_cmd;
            va <= in_va;
            ppn <= s_tdata[81:38];
            perm <= s_tdata[85:82];
            release_req <= s_tdata[86];
            count <= in_count;
            lvl <= 2'd2;
            cur_page <= '0;
            res_status <= ST_OK;
            res_pa <= '0;
            res_rel <= 1'b0;
            res_chunk <= '0;
            if ((in_cmd == CMD_MAP || in_cmd == CMD_UNMAP) && in_va[11:0] != 12'd0) begin
              res_status <= ST_MISALIGNED;
              state <= S_DONE;
            end else if ((in_cmd == CMD_READ_CHECK || in_cmd == CMD_WRITE_CHECK)
                         && in_count == '0) begin
              state <= S_DONE;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (ev_done) begin
            res_status <= ev_status;
            res_pa <= ev_pa;
            res_rel <= ev_rel;
            res_chunk <= ev_chunk;
            state <= S_DONE;
          end else begin
            cur_page <= ev_page;
            lvl <= lvl - 2'd1;
            state <= S_READ;
          end
          if (ev_alloc) begin
            next_free <= next_free + NW'(1);
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            out_status <= res_status;
            out_pa <= res_pa;
            out_rel <= res_rel;
            out_chunk <= res_chunk;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_free_bounded: assert property (@(posedge clk) disable iff (rst)
    next_free <= NW'(TABLE_PAGES) && next_free != '0)
    else $error("table page counter out of range");

  a_free_steps: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && next_free != $past(next_free) |-> next_free == $past(next_free) + NW'(1))
    else $error("table page counter moved by more than one");

  a_misaligned: assert property (@(posedge clk) disable iff (rst)
    in_fire && (in_cmd == CMD_MAP || in_cmd == CMD_UNMAP) && in_va[11:0] != 12'd0
    |=> state == S_DONE && res_status == ST_MISALIGNED)
    else $error("misaligned page item started a walk");

  a_no_write_on_read: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |-> !mem_we)
    else $error("table write collides with a walk read");

  a_release_unmap: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && res_rel |-> cmd == CMD_UNMAP && res_status == ST_OK)
    else $error("page release reported outside a successful unmap");

endmodule

`default_nettype wire
